FILE: src/shabs_pkg.sv
`timescale 1ns / 1ps

package shabs_pkg;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam int BLK_BYTES = 64;
    localparam int BCNT_W    = $clog2(BLK_BYTES);
    localparam int ROUNDS    = 64;
    localparam int RND_W     = $clog2(ROUNDS);
    localparam int LEN_POS   = 56;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // one queued transfer, already stripped of items that do nothing
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eom;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
        ror32 = (v >> s) | (v << (32 - s));
    endfunction

endpackage

FILE: src/shabs_front.sv
`timescale 1ns / 1ps

module shabs_front import shabs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_end_of_message,
    output t_head      o_head,
    input  logic       i_pop
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              n_push;
    logic              n_pop;

    assign o_stall = (r_cnt == QCNT_W'(QDEPTH));
    // an item with neither a byte nor an end is taken and dropped here
    assign n_push  = i_valid && !o_stall && (i_has_byte || i_end_of_message);
    assign n_pop   = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (n_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({n_push, n_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wp] <= '{data: i_data_byte, has_byte: i_has_byte, eom: i_end_of_message};
        end
    end

endmodule

FILE: src/shabs_back.sv
`timescale 1ns / 1ps

module shabs_back import shabs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_head       i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FIN   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state            r_state;
    t_state            r_after;
    logic [31:0]       r_w [16];
    logic [31:0]       r_h [8];
    logic [31:0]       r_v [8];
    logic [RND_W-1:0]  r_round;
    logic [BCNT_W-1:0] r_cnt;
    logic [63:0]       r_len;
    logic              r_len_ok;
    logic              r_pad_first;
    logic [1:0]        r_oidx;
    logic              r_out_valid;
    logic [63:0]       r_out_word;
    logic [1:0]        r_out_idx;
    logic              r_out_last;

    logic              n_wr_en;
    logic [7:0]        n_wr_byte;
    logic [7:0]        n_len_byte;
    logic              n_ok_now;
    logic              n_out_load;
    logic [31:0]       n_t1;
    logic [31:0]       n_t2;
    logic [31:0]       n_wnew;
    logic [31:0]       n_w1;
    logic [31:0]       n_w14;

    assign o_pop = (r_state == S_IDLE) && i_head.valid;

    // length goes out big-endian in the last eight bytes
    assign n_len_byte = r_len[{~r_cnt[2:0], 3'b000} +: 8];
    assign n_ok_now   = r_pad_first ? (r_cnt < BCNT_W'(LEN_POS)) : r_len_ok;

    always_comb begin
        n_wr_en   = 1'b0;
        n_wr_byte = i_head.cmd.data;
        case (r_state)
            S_IDLE: begin
                n_wr_en = i_head.valid && i_head.cmd.has_byte;
            end
            S_PAD: begin
                n_wr_en = 1'b1;
                if (r_pad_first) begin
                    n_wr_byte = PAD_BYTE;
                end else if (r_len_ok && r_cnt >= BCNT_W'(LEN_POS)) begin
                    n_wr_byte = n_len_byte;
                end else begin
                    n_wr_byte = 8'h00;
                end
            end
            default: n_wr_en = 1'b0;
        endcase
    end

    // round arithmetic; schedule is kept as a shift line, r_w[0] is this round's word
    assign n_w1  = r_w[1];
    assign n_w14 = r_w[14];
    assign n_wnew = r_w[0] + r_w[9]
                  + (ror32(n_w1, 7) ^ ror32(n_w1, 18) ^ (n_w1 >> 3))
                  + (ror32(n_w14, 17) ^ ror32(n_w14, 19) ^ (n_w14 >> 10));
    assign n_t1 = r_v[7] + (ror32(r_v[4], 6) ^ ror32(r_v[4], 11) ^ ror32(r_v[4], 25))
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + K_TAB[r_round] + r_w[0];
    assign n_t2 = (ror32(r_v[0], 2) ^ ror32(r_v[0], 13) ^ ror32(r_v[0], 22))
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign n_out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    // control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_round     <= '0;
            r_cnt       <= '0;
            r_len       <= '0;
            r_len_ok    <= 1'b0;
            r_pad_first <= 1'b0;
            r_oidx      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= IV[i];
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_pad_first <= 1'b1;
                        if (i_head.cmd.has_byte) begin
                            r_len <= r_len + 64'd8;
                            r_cnt <= r_cnt + 1'b1;
                            if (r_cnt == BCNT_W'(BLK_BYTES - 1)) begin
                                r_state <= S_ROUND;
                                r_round <= '0;
                                r_after <= i_head.cmd.eom ? S_PAD : S_IDLE;
                            end else if (i_head.cmd.eom) begin
                                r_state <= S_PAD;
                            end
                        end else begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_pad_first) begin
                        r_pad_first <= 1'b0;
                    end
                    if (r_cnt == BCNT_W'(BLK_BYTES - 1)) begin
                        // block full: compress it; if the length did not fit, spill into one more block
                        r_len_ok <= 1'b1;
                        r_state  <= S_ROUND;
                        r_round  <= '0;
                        r_after  <= n_ok_now ? S_OUT : S_PAD;
                    end else if (r_pad_first) begin
                        r_len_ok <= n_ok_now;
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 1'b1;
                    if (r_round == RND_W'(ROUNDS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_oidx  <= '0;
                    r_state <= r_after;
                end
                S_OUT: begin
                    if (n_out_load) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 2'd3) begin
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= IV[i];
                            end
                            r_len   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            for (int i = 0; i < 6; i++) begin
                                r_h[i] <= r_h[i + 2];
                            end
                            r_h[6] <= r_h[0];
                            r_h[7] <= r_h[1];
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: block words, working variables, output register
    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_w[r_cnt[BCNT_W-1:2]][{~r_cnt[1:0], 3'b000} +: 8] <= n_wr_byte;
        end
        if (r_state == S_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= n_wnew;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + n_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= n_t1 + n_t2;
        end else begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end
        if (n_out_load) begin
            r_out_word <= {r_h[0], r_h[1]};
            r_out_idx  <= r_oidx;
            r_out_last <= (r_oidx == 2'd3);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = r_out_last;

    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROUND) |-> (r_round == '0))
        else $error("round counter running outside compression");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_idx == 2'd3)))
        else $error("last flag does not match word index");

    a_round_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ROUND) && ($past(r_state) != S_ROUND)) |-> (r_cnt == '0))
        else $error("compression started on a partial block");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND || r_state == S_FIN) |-> !o_pop)
        else $error("queue popped during compression");

endmodule

FILE: src/sha256_byte_stream.sv
`timescale 1ns / 1ps

// channel | direction | transfer when         | payload
// input   | in        | i_valid & !o_stall    | i_data_byte, i_has_byte, i_end_of_message
// output  | out       | o_valid & !i_stall    | o_digest_word, o_word_index, o_last_word
//
// A byte is written into the block in the back end; a full block then adds 64 rounds and the add.
// Message end: padding bytes are written one at a time up to the block end, then each
// padding block (one or two) is compressed, then four output transfers follow.
// The round loop computes one round a cycle; padding is written byte-wide.
// Synchronous active-low reset restores the initial hash values and clears counts.
// Either side may stall: a four-entry queue sits in front, a result register behind.

module sha256_byte_stream import shabs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    t_head w_head;
    logic  w_pop;

    shabs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_head           (w_head),
        .i_pop            (w_pop)
    );

    shabs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

FILE: bench/sha256_byte_stream_tb.sv
`timescale 1ns / 1ps

module sha256_byte_stream_tb;

    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEM_TARGET  = 460;
    localparam int CALM_FROM    = 390;
    localparam int WORD_TARGET  = 64;

    localparam bit [7:0] PAD_MARK = 8'h80;
    localparam int       LEN_SLOT = 56;

    localparam bit [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct {
        bit [63:0] word;
        bit [1:0]  index;
        bit        last;
    } t_digest_part;

    class t_scoreboard;
        bit [31:0]    hash_state [8];
        bit [7:0]     block_bytes [64];
        int unsigned  fill;
        bit [63:0]    bit_count;
        t_digest_part awaited [$];
        int unsigned  errors;
        int unsigned  messages;
        int unsigned  words_checked;

        function new();
            errors = 0;
            messages = 0;
            words_checked = 0;
            restart();
        endfunction

        function void restart();
            foreach (hash_state[i]) hash_state[i] = INIT_HASH[i];
            fill = 0;
            bit_count = '0;
        endfunction

        function bit [31:0] rotr(bit [31:0] v, int unsigned s);
            return (v >> s) | (v << (32 - s));
        endfunction

        function void compress();
            bit [31:0] w [16];
            bit [31:0] v [8];
            bit [31:0] wi, t1, t2, s0, s1, x15, x2;
            for (int i = 0; i < 16; i++)
                w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
            foreach (v[i]) v[i] = hash_state[i];
            for (int r = 0; r < 64; r++) begin
                if (r < 16) begin
                    wi = w[r];
                end else begin
                    // rolling 16-word schedule
                    x15 = w[(r + 1) % 16];
                    x2  = w[(r + 14) % 16];
                    s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
                    s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
                    wi = w[r % 16] + s0 + w[(r + 9) % 16] + s1;
                    w[r % 16] = wi;
                end
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
                     ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wi;
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
                     ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            foreach (hash_state[i]) hash_state[i] += v[i];
        endfunction

        function void note_input(bit [7:0] data, bit has_byte, bit eom);
            t_digest_part part;
            if (has_byte) begin
                block_bytes[fill] = data;
                bit_count += 64'd8;
                fill++;
                if (fill == 64) begin
                    compress();
                    fill = 0;
                end
            end
            if (!eom) return;
            block_bytes[fill] = PAD_MARK;
            fill++;
            // no room left for the length: pad out and spill into an extra block
            if (fill > LEN_SLOT) begin
                while (fill < 64) begin
                    block_bytes[fill] = 8'h00;
                    fill++;
                end
                compress();
                fill = 0;
            end
            while (fill < LEN_SLOT) begin
                block_bytes[fill] = 8'h00;
                fill++;
            end
            for (int k = 0; k < 8; k++)
                block_bytes[LEN_SLOT + k] = bit_count[63 - 8*k -: 8];
            compress();
            for (int k = 0; k < 4; k++) begin
                part.word  = {hash_state[2*k], hash_state[2*k+1]};
                part.index = k[1:0];
                part.last  = (k == 3);
                awaited = {awaited, part};
            end
            messages++;
            restart();
        endfunction

        function void check_result(logic [63:0] word, logic [1:0] index, logic last);
            t_digest_part want;
            if (awaited.size() == 0) begin
                $error("digest transfer with none awaited: digest_word %h word_index %0d",
                       word, index);
                errors++;
                return;
            end
            want = awaited.pop_front();
            words_checked++;
            if (word !== want.word) begin
                $error("digest_word: expected %h, got %h", want.word, word);
                errors++;
            end
            if (index !== want.index) begin
                $error("word_index: expected %0d, got %0d", want.index, index);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_word: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_has_byte;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    t_scoreboard sb = new();

    int unsigned items_sent   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sender_rate  = 0;
    bit          calm         = 1'b0;
    bit          hold_done    = 1'b0;

    sha256_byte_stream i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // one transfer on the input side, with an optional idle burst in front
    task automatic send_item(bit [7:0] data, bit has_byte, bit eom);
        int gap;
        if (!calm && sender_rate != 0 && $urandom_range(0, 15) < sender_rate) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            i_valid     = 1'b0;
            i_data_byte = 8'($urandom_range(0, 255));
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid          = 1'b1;
        i_data_byte      = data;
        i_has_byte       = has_byte;
        i_end_of_message = eom;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(data, has_byte, eom);
        if (has_byte || eom) items_sent++;
    endtask

    task automatic send_random_message();
        int len;
        int kind;
        bit end_alone;
        kind = $urandom_range(0, 9);
        if (kind < 5)      len = $urandom_range(0, 8);
        else if (kind < 8) len = $urandom_range(52, 66);   // around the padding boundary
        else if (kind < 9) len = $urandom_range(110, 130);
        else               len = $urandom_range(0, 140);
        end_alone = (len == 0) || ($urandom_range(0, 2) == 0);
        sender_rate = calm ? 0 : $urandom_range(0, 3);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, !end_alone && (n == len - 1));
        end
        if (end_alone)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_data_byte      = 8'h00;
        i_has_byte       = 1'b0;
        i_end_of_message = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty message, ignored items, single bytes at the extremes, "abc"
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'haa, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);

        while (items_sent < ITEM_TARGET || sb.messages * 4 < WORD_TARGET) begin
            if (items_sent >= CALM_FROM) calm = 1'b1;
            send_random_message();
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d input transfers, %0d messages from empty to multi-block hashed,",
                 items_sent, sb.messages);
        $display("%0d digest words checked; output held off once for %0d cycles",
                 sb.words_checked, HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("sha256_byte_stream test passed");
        end else begin
            $display("sha256_byte_stream test failed");
        end
        $finish;
    end

    // output side: random stall bursts, one long hold-off to back the block up
    initial begin
        int unsigned rate;
        int          burst;
        rate = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0) rate = $urandom_range(0, 3);
            if (!hold_done && items_sent >= 120) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
                i_stall = 1'b0;
            end else if (!calm && rate != 0 && $urandom_range(0, 15) < rate) begin
                burst = $urandom_range(1, 9);
                i_stall = 1'b1;
                repeat (burst) @(negedge i_clk);
                i_stall = 1'b0;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_digest_word, o_word_index, o_last_word);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sha256_byte_stream test failed");
            $finish;
        end
    end

endmodule

FILE: sim.f
src/shabs_pkg.sv
src/shabs_front.sv
src/shabs_back.sv
src/sha256_byte_stream.sv
bench/sha256_byte_stream_tb.sv
